// ===== sv/tis_pkg.sv =====
// Shared types and constants for the trie insert/search core.
// No dependencies; imported by the RAM and the top-level module.

package tis_pkg;

	// Field widths of the stream words.
	localparam int LETTER_W   = 5;
	localparam int S_TDATA_W  = 8;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 8;

	// Operation codes carried in s_tuser[0].
	localparam logic OP_SEARCH = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Status codes returned with each result.
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic status;
		logic found;
	} tis_result_t;

endpackage

// ===== sv/tis_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Uses tis_pkg only for the common import convention; holds child and end-mark stores.

module tis_ram
	import tis_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/trie_insert_search_core.sv =====
// Trie insert/search core: a 26-letter trie in a fixed node pool held in two RAMs.
// Depends on tis_pkg and tis_ram.
//
//  channel | dir | payload                                   | last
//  s_*     | in  | tdata[4:0] letter; tuser[0] operation,    | tlast = word end
//          |     | tuser[1] has_letter                       |
//  m_*     | out | tdata[0] found, tdata[1] status           | none
//
// A letter is accepted in ST_IDLE; in ST_WALK the child-table read returns and the walk moves on.
// A live word then ends in ST_MARK for the end-mark access, a search also in ST_FIN.
// After reset a clearing pass writes every child-table entry while s_tready stays low.
// A word arriving with a result still unread in the output register waits in s_tready.

module trie_insert_search_core
	import tis_pkg::*;
#(
	parameter int NODES   = 256,
	parameter int LETTERS = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] letter, zero padded
	input  logic [S_TUSER_W-1:0] s_tuser,   // [0] operation, [1] has_letter
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [0] found, [1] status, zero padded
);

	localparam int NW    = $clog2(NODES);
	localparam int DEPTH = NODES * LETTERS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_MARK,
		ST_FIN
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   cursor_q;
	logic [NW:0]     next_free_q;
	logic            failed_q;
	logic            op_q;
	logic            end_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   clr_q;
	logic            m_tvalid_q;
	tis_result_t     result_q;

	logic            child_we;
	logic [AW-1:0]   child_addr;
	logic [NW-1:0]   child_wdata;
	logic [NW-1:0]   child_rdata;
	logic            mark_we;
	logic [NW-1:0]   mark_addr;
	logic [0:0]      mark_wdata;
	logic [0:0]      mark_rdata;

	logic [LETTER_W-1:0] letter;
	logic            op_in;
	logic            has_letter;
	logic            letter_ok;
	logic            walk;
	logic            fail_now;
	logic            fail_end;
	logic [AW-1:0]   walk_addr;
	logic            accept;
	logic            pool_free;
	logic            child_miss;

	assign letter     = s_tdata[LETTER_W-1:0];
	assign op_in      = s_tuser[0];
	assign has_letter = s_tuser[1];
	assign letter_ok  = ({4'b0, letter} < 9'(LETTERS));
	assign walk       = has_letter && !failed_q && letter_ok;
	assign fail_now   = failed_q || (has_letter && !letter_ok);
	assign walk_addr  = AW'(cursor_q) * AW'(LETTERS) + AW'(letter);
	assign s_tready   = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept     = s_tvalid && s_tready;
	// A failed word ending on this item loads the output register at once.
	assign fail_end   = accept && !walk && s_tlast && fail_now;
	assign pool_free  = (next_free_q < (NW+1)'(NODES));
	assign child_miss = (child_rdata == '0);

	// One access per RAM per cycle; the state decides who owns the port.
	always_comb begin
		child_we    = 1'b0;
		child_addr  = walk_addr;
		child_wdata = '0;
		mark_we     = 1'b0;
		mark_addr   = cursor_q;
		mark_wdata  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				child_we   = 1'b1;
				child_addr = clr_q;
				mark_addr  = clr_q[NW-1:0];
				mark_we    = ((AW+1)'(clr_q) < (AW+1)'(NODES));
			end
			ST_WALK: begin
				child_addr  = addr_q;
				child_wdata = next_free_q[NW-1:0];
				child_we    = child_miss && (op_q == OP_INSERT) && pool_free;
			end
			ST_MARK: begin
				mark_we    = (op_q == OP_INSERT);
				mark_wdata = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tis_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_child (
		.clk   (clk),
		.we    (child_we),
		.addr  (child_addr),
		.wdata (child_wdata),
		.rdata (child_rdata)
	);

	tis_ram #(.WIDTH(1), .DEPTH(NODES)) u_mark (
		.clk   (clk),
		.we    (mark_we),
		.addr  (mark_addr),
		.wdata (mark_wdata),
		.rdata (mark_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cursor_q    <= '0;
			next_free_q <= (NW+1)'(1);
			failed_q    <= 1'b0;
			op_q        <= OP_SEARCH;
			end_q       <= 1'b0;
			clr_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !fail_end) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q  <= op_in;
						end_q <= s_tlast;
						if (walk) begin
							addr_q  <= walk_addr;
							state_q <= ST_WALK;
						end else if (s_tlast && fail_now) begin
							result_q   <= '{status: (op_in == OP_INSERT) ? STATUS_FULL : STATUS_OK,
								found: 1'b0};
							m_tvalid_q <= 1'b1;
							cursor_q   <= '0;
							failed_q   <= 1'b0;
						end else if (s_tlast) begin
							state_q <= ST_MARK;
						end else begin
							failed_q <= fail_now;
						end
					end
				end
				ST_WALK: begin
					if (!child_miss) begin
						cursor_q <= child_rdata;
						state_q  <= end_q ? ST_MARK : ST_IDLE;
					end else if ((op_q == OP_INSERT) && pool_free) begin
						cursor_q    <= next_free_q[NW-1:0];
						next_free_q <= next_free_q + (NW+1)'(1);
						state_q     <= end_q ? ST_MARK : ST_IDLE;
					end else if (end_q) begin
						// Miss or full pool on the last letter ends the word at once.
						result_q   <= '{status: (op_q == OP_INSERT) ? STATUS_FULL : STATUS_OK,
							found: 1'b0};
						m_tvalid_q <= 1'b1;
						cursor_q   <= '0;
						failed_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						failed_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_MARK: begin
					if (op_q == OP_INSERT) begin
						result_q   <= '{status: STATUS_OK, found: 1'b1};
						m_tvalid_q <= 1'b1;
						cursor_q   <= '0;
						failed_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					result_q   <= '{status: STATUS_OK, found: mark_rdata[0]};
					m_tvalid_q <= 1'b1;
					cursor_q   <= '0;
					failed_q   <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W-2)'(0), result_q.status, result_q.found};

`ifndef SYNTHESIS
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= (NW+1)'(NODES))
		else $error("next free node ran past the pool");

	a_cursor_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		(NW+1)'(cursor_q) < next_free_q)
		else $error("cursor points at an unallocated node");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_tready)
		else $error("input taken during the clearing pass");

	a_alloc_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(child_we && state_q != ST_CLEAR) |-> (op_q == OP_INSERT && pool_free))
		else $error("child written outside an insert with free nodes");

	a_alloc_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(child_we && state_q == ST_WALK) |=> next_free_q == $past(next_free_q) + (NW+1)'(1))
		else $error("allocation did not advance the free pointer");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for trie_insert_search_core: a directed table, then random words.
// Results are checked against a trie model kept here or typed table rows. Depends on tis_pkg and the core.

module testbench;
	import tis_pkg::*;

	localparam int NODES        = 256;
	localparam int LETTERS      = 26;
	localparam int MAX_WORDS    = 512;
	localparam int MAX_LEN      = 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam int NUM_ROWS     = 26;

	typedef struct packed {
		logic       op;
		logic [4:0] letter;
		logic       has_letter;
		logic       last;
		logic       typed;
		logic       found;
		logic       status;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // [4:0] letter, zero padded
	logic [S_TUSER_W-1:0] s_tuser = '0;   // [0] operation, [1] has_letter
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [0] found, [1] status, zero padded

	// Trie state as the testbench sees it.
	bit [7:0]    child_of [NODES*LETTERS];
	bit          word_marked [NODES];
	bit [8:0]    free_node = 9'd1;
	bit [7:0]    walk_node = 8'd0;
	bit          walk_dead = 1'b0;

	tis_result_t pending_results [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          cycles = 0;
	bit          sender_quiet = 1'b0;

	// Words inserted so far, reused (sometimes cut short or extended) for later inserts and searches.
	bit [4:0]    dict_word [MAX_WORDS][MAX_LEN];
	int          dict_len [MAX_WORDS];
	int          dict_count = 0;

	// op, letter, has_letter, last, typed, found, status
	stim_row_t script [NUM_ROWS] = '{
		{OP_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, STATUS_OK},
		{OP_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, STATUS_OK},
		{OP_INSERT, 5'd25, 1'b1, 1'b1, 1'b1, 1'b1, STATUS_OK},
		{OP_SEARCH, 5'd25, 1'b1, 1'b1, 1'b1, 1'b1, STATUS_OK},
		{OP_SEARCH, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd26, 1'b1, 1'b1, 1'b1, 1'b0, STATUS_FULL},
		{OP_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd21, 1'b0, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd1,  1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd1,  1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd2,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd1,  1'b1, 1'b1, 1'b1, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd3,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd4,  1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd2,  1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_INSERT, 5'd1,  1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK},
		{OP_SEARCH, 5'd9,  1'b0, 1'b1, 1'b0, 1'b0, STATUS_OK}
	};

	trie_insert_search_core #(
		.NODES(NODES),
		.LETTERS(LETTERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Walks one letter through the trie and returns 1 with the word's outcome on its last letter.
	function automatic bit trie_step(input logic op, input logic [4:0] letter,
			input logic has_letter, input logic last, output tis_result_t res);
		int slot;
		bit [7:0] child;
		res = '0;
		if (has_letter && !walk_dead) begin
			if (letter >= LETTERS) begin
				walk_dead = 1'b1;
			end else begin
				slot = int'(walk_node) * LETTERS + int'(letter);
				child = child_of[slot];
				if (child == 0) begin
					if (op != OP_INSERT || free_node >= NODES) begin
						walk_dead = 1'b1;
					end else begin
						child = free_node[7:0];
						child_of[slot] = child;
						free_node = free_node + 9'd1;
					end
				end
				if (!walk_dead)
					walk_node = child;
			end
		end
		if (!last)
			return 1'b0;
		if (walk_dead) begin
			res.found = 1'b0;
			res.status = (op == OP_INSERT) ? STATUS_FULL : STATUS_OK;
		end else if (op == OP_INSERT) begin
			word_marked[walk_node] = 1'b1;
			res.found = 1'b1;
			res.status = STATUS_OK;
		end else begin
			res.found = word_marked[walk_node];
			res.status = STATUS_OK;
		end
		walk_node = 8'd0;
		walk_dead = 1'b0;
		return 1'b1;
	endfunction

	// Presents one item of a word on the input stream and records what the trie should answer.
	task automatic send_item(input logic op, input logic [4:0] letter, input logic has_letter,
			input logic last, input bit typed, input tis_result_t typed_res);
		int pick;
		int gap;
		tis_result_t res;
		gap = 0;
		if (!sender_quiet) begin
			pick = $urandom_range(0, 99);
			if (pick >= 90)
				gap = $urandom_range(5, 30);
			else if (pick >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, letter};
		s_tuser <= {has_letter, op};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		if (trie_step(op, letter, has_letter, last, res))
			pending_results.push_back(typed ? typed_res : res);
		items_sent++;
	endtask

	// Mostly well-formed words, fresh or taken from earlier inserts; the rest is noise.
	task automatic send_random_word(input int alpha_hi, input int max_len);
		int n;
		int src;
		int pick;
		bit [4:0] w [MAX_LEN];
		logic op;
		logic [4:0] letter;
		logic has_letter;
		sender_quiet = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 99) < 12) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				op = $urandom_range(0, 1) ? OP_INSERT : OP_SEARCH;
				has_letter = ($urandom_range(0, 5) != 0);
				if (!has_letter)
					letter = 5'($urandom_range(0, 31));
				else if ($urandom_range(0, 7) == 0)
					letter = 5'($urandom_range(LETTERS, 31));
				else
					letter = 5'($urandom_range(0, alpha_hi));
				send_item(op, letter, has_letter, i == n - 1, 1'b0, '0);
			end
		end else begin
			op = $urandom_range(0, 1) ? OP_INSERT : OP_SEARCH;
			if (dict_count > 0 && $urandom_range(0, 1)) begin
				src = $urandom_range(0, dict_count - 1);
				n = dict_len[src];
				for (int i = 0; i < n; i++)
					w[i] = dict_word[src][i];
				pick = $urandom_range(0, 99);
				if (pick < 25 && n > 1) begin
					n = $urandom_range(1, n - 1);
				end else if (pick < 40 && n < MAX_LEN) begin
					w[n] = 5'($urandom_range(0, alpha_hi));
					n++;
				end
			end else begin
				n = $urandom_range(1, max_len);
				for (int i = 0; i < n; i++)
					w[i] = 5'($urandom_range(0, alpha_hi));
			end
			for (int i = 0; i < n; i++)
				send_item(op, w[i], 1'b1, i == n - 1, 1'b0, '0);
			if (op == OP_INSERT && dict_count < MAX_WORDS) begin
				for (int i = 0; i < n; i++)
					dict_word[dict_count][i] = w[i];
				dict_len[dict_count] = n;
				dict_count++;
			end
		end
	endtask

	// Receiver backpressure: ready runs broken by stalls, most short and a few long.
	initial begin : result_ready
		int run_len;
		int stall_len;
		int pick;
		@(posedge clk);
		forever begin
			run_len = $urandom_range(1, 40);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 50)
				stall_len = 0;
			else if (pick < 85)
				stall_len = $urandom_range(1, 3);
			else
				stall_len = $urandom_range(5, 40);
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		tis_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("result word with nothing expected: found=%0b status=%0b",
						m_tdata[0], m_tdata[1]);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.found || m_tdata[1] !== want.status) begin
					if (mismatches < 10)
						$display("mismatch at %0t: expected found=%0b status=%0b, got found=%0b status=%0b",
							$realtime, want.found, want.status, m_tdata[0], m_tdata[1]);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		tis_result_t typed_res;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < NUM_ROWS; r++) begin
			typed_res.found = script[r].found;
			typed_res.status = script[r].status;
			send_item(script[r].op, script[r].letter, script[r].has_letter, script[r].last,
				script[r].typed, typed_res);
		end
		// Small alphabet and short words so searches often hit stored words.
		while (items_sent < 350)
			send_random_word(3, 4);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		// Full alphabet and longer words; inserts here run the node pool dry.
		while (items_sent < 750)
			send_random_word(LETTERS - 1, MAX_LEN);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== trie_insert_search_core.f =====
sv/tis_pkg.sv
sv/tis_ram.sv
sv/trie_insert_search_core.sv
verif/testbench.sv
